/* src/awa_pkg.sv */
// ----------------------------------------------------------------------------
// awa_pkg
// Shared sizes, reset values, register codes and types of the averaged
// window alarm.
// ----------------------------------------------------------------------------
package awa_pkg;

  localparam int WINDOW_LEN  = 8;
  localparam int SAMPLE_BITS = 8;
  localparam int AVG_BITS    = 8;
  localparam int LIMIT_BITS  = 8;
  localparam int SLOT_BITS   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_BITS   = $clog2(WINDOW_LEN + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
  localparam int CNT_BITS    = $clog2(SUM_BITS + 1);
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [LIMIT_BITS-1:0] TEMP_LOW_RESET  = 8'd10;
  localparam logic [LIMIT_BITS-1:0] TEMP_HIGH_RESET = 8'd35;
  localparam logic [LIMIT_BITS-1:0] HUMI_LOW_RESET  = 8'd30;
  localparam logic [LIMIT_BITS-1:0] HUMI_HIGH_RESET = 8'd80;

  typedef enum logic [1:0] {
    REG_TEMP_LOW  = 2'd0,
    REG_TEMP_HIGH = 2'd1,
    REG_HUMI_LOW  = 2'd2,
    REG_HUMI_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIVS,
    ST_DIVW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 upd_en;
    logic                 full;
    logic [SLOT_BITS-1:0] slot;
  } chan_ctl_t;

endpackage

/* src/awa_div.sv */
// ----------------------------------------------------------------------------
// awa_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the top of the register as quotient bits shift in below.
// ----------------------------------------------------------------------------
module awa_div
  import awa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SUM_BITS-1:0]  dividend,
  input  logic [FILL_BITS-1:0] divisor,
  output logic                 busy,
  output logic [SUM_BITS-1:0]  quotient
);

  logic [SUM_BITS-1:0]  dq_r, dq_nxt;
  logic [FILL_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [FILL_BITS:0]   trial;
  logic                 qbit;

  always_comb begin
    trial    = {rem_r, dq_r[SUM_BITS-1]};
    qbit     = (trial >= {1'b0, divisor});
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(SUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract where the trial remainder fits, keep it otherwise
      rem_nxt  = qbit ? FILL_BITS'(trial - {1'b0, divisor}) : FILL_BITS'(trial);
      dq_nxt   = {dq_r[SUM_BITS-2:0], qbit};
      cnt_nxt  = cnt_r - CNT_BITS'(1);
      busy_nxt = (cnt_r != CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

/* src/awa_chan.sv */
// ----------------------------------------------------------------------------
// awa_chan
// One channel of the window: sample ring and running sum.
// ----------------------------------------------------------------------------
module awa_chan
  import awa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  chan_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SUM_BITS-1:0]    sum
);

  logic [SAMPLE_BITS-1:0] ring_r [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] old_r;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;

  // fetch the oldest sample, then overwrite its slot
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      old_r <= ring_r[ctl.slot];
    end
    if (ctl.upd_en) begin
      ring_r[ctl.slot] <= sample;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.upd_en) begin
      if (ctl.full) begin
        sum_nxt = sum_r - SUM_BITS'(old_r) + SUM_BITS'(sample);
      end else begin
        sum_nxt = sum_r + SUM_BITS'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

/* src/averaged_window_alarm.sv */
// ----------------------------------------------------------------------------
// averaged_window_alarm
// Moving average over the last eight temperature and humidity readings,
// with low and high limit alarms per channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request: a temperature
//   and a humidity sample. Each request yields one result on the output
//   channel (out_valid/out_stall): both truncated averages, the two
//   channel alarms and their OR.
//   A request passes the read, sum, divide-start, divide-wait and finish
//   steps in that order; the two bit-serial dividers work one quotient
//   bit per cycle over the 11-bit sum.
//   in_stall stays high while a request is in flight. A finished result
//   sits in the output register; the next request is taken meanwhile and
//   only waits at its last step if the receiver still stalls the previous
//   result.
//   Limits are written over the APB port (byte addresses 0, 4, 8, 12).
//   Reset clears the sums, fill count and write slot and loads the default
//   limits; ring entries are read only once written.
// ----------------------------------------------------------------------------
module averaged_window_alarm
  import awa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_temp_sample,
  input  logic [SAMPLE_BITS-1:0] in_humi_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [AVG_BITS-1:0]    out_temp_average,
  output logic [AVG_BITS-1:0]    out_humi_average,
  output logic                   out_temp_flag,
  output logic                   out_humi_flag,
  output logic                   out_any_alarm,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready
);

  state_t                 state_r, state_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [SAMPLE_BITS-1:0] temp_smp_r, humi_smp_r;
  logic [LIMIT_BITS-1:0]  temp_low_r, temp_high_r, humi_low_r, humi_high_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_BITS-1:0]    temp_avg_r, humi_avg_r;
  logic                   temp_flag_r, humi_flag_r;
  logic                   accept, full, load_out, div_start, cfg_wr;
  chan_ctl_t              ctl;
  logic [SUM_BITS-1:0]    temp_sum, humi_sum, temp_q, humi_q;
  logic                   temp_busy, humi_busy;
  logic [AVG_BITS-1:0]    temp_avg, humi_avg;
  reg_idx_t               reg_idx;

  assign accept = in_valid && !in_stall;
  assign full   = (fill_r >= FILL_BITS'(WINDOW_LEN));

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_low_r  <= TEMP_LOW_RESET;
      temp_high_r <= TEMP_HIGH_RESET;
      humi_low_r  <= HUMI_LOW_RESET;
      humi_high_r <= HUMI_HIGH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEMP_LOW:  temp_low_r  <= pwdata[LIMIT_BITS-1:0];
        REG_TEMP_HIGH: temp_high_r <= pwdata[LIMIT_BITS-1:0];
        REG_HUMI_LOW:  humi_low_r  <= pwdata[LIMIT_BITS-1:0];
        REG_HUMI_HIGH: humi_high_r <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP_LOW:  prdata = DATA_BITS'(temp_low_r);
      REG_TEMP_HIGH: prdata = DATA_BITS'(temp_high_r);
      REG_HUMI_LOW:  prdata = DATA_BITS'(humi_low_r);
      REG_HUMI_HIGH: prdata = DATA_BITS'(humi_high_r);
      default:       prdata = '0;
    endcase
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    slot_nxt   = slot_r;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.upd_en = 1'b0;
    ctl.full   = full;
    ctl.slot   = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // fetch the oldest samples at the write slot
        ctl.rd_en = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // update sums and rings, advance fill count and slot
        ctl.upd_en = 1'b1;
        if (!full) begin
          fill_nxt = fill_r + FILL_BITS'(1);
        end
        slot_nxt  = (slot_r == SLOT_BITS'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_BITS'(1);
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (!temp_busy && !humi_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      temp_smp_r <= in_temp_sample;
      humi_smp_r <= in_humi_sample;
    end
  end

  // ---- datapath ----
  awa_chan u_temp_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (temp_smp_r),
    .sum    (temp_sum)
  );

  awa_chan u_humi_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (humi_smp_r),
    .sum    (humi_sum)
  );

  // the fill count has already advanced, so it is the number of samples held
  awa_div u_temp_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (temp_sum),
    .divisor  (fill_r),
    .busy     (temp_busy),
    .quotient (temp_q)
  );

  awa_div u_humi_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (humi_sum),
    .divisor  (fill_r),
    .busy     (humi_busy),
    .quotient (humi_q)
  );

  assign temp_avg = AVG_BITS'(temp_q);
  assign humi_avg = AVG_BITS'(humi_q);

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      temp_avg_r  <= temp_avg;
      humi_avg_r  <= humi_avg;
      temp_flag_r <= (temp_avg < temp_low_r) || (temp_avg > temp_high_r);
      humi_flag_r <= (humi_avg < humi_low_r) || (humi_avg > humi_high_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_average = temp_avg_r;
  assign out_humi_average = humi_avg_r;
  assign out_temp_flag    = temp_flag_r;
  assign out_humi_flag    = humi_flag_r;
  assign out_any_alarm    = temp_flag_r | humi_flag_r;

`ifndef ASSERT_OFF
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("accepted request did not start a ring read");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (temp_busy || humi_busy) |-> state_r == ST_DIVW)
    else $error("divider busy outside the divide wait");

  a_load_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled result");
`endif

endmodule
